### rtl/core/tiled_worley_cell_distance_3d_unit_assert.svh
// assertion macros used by the rtl of the tiled worley distance unit
`ifndef TILED_WORLEY_CELL_DISTANCE_3D_UNIT_ASSERT_SVH
`define TILED_WORLEY_CELL_DISTANCE_3D_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define TWCD_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TWCD_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TWCD_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/twcd_pkg.sv
// shared constants and helpers of the tiled worley distance unit
`timescale 1ns / 1ps
package twcd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int PERIOD_W      = 16;
    localparam int SEED_W        = 32;
    localparam int DIST_W        = 17;
    localparam int OFFSET_BITS   = 10;
    localparam int NUM_NB        = 27;
    localparam int TREE_LVLS     = 5;
    localparam int QUEUE_DEPTH   = 4;
    localparam int APB_DW        = 32;
    localparam int APB_AW        = 3;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MUL_Z = 32'd2654435761;
    localparam logic [31:0] HASH_MIX   = 32'd1274126177;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd16;
    localparam logic [SEED_W-1:0]   SEED_RESET   = 32'd0;
    localparam logic [DIST_W-1:0]   OUT_MAX      = 17'd131071;

    localparam logic REG_TILE_PERIOD = 1'b0;
    localparam logic REG_HASH_SEED   = 1'b1;

    // entries left at a given level of the min tree
    function automatic int lvl_size(input int lvl);
        return (NUM_NB + (1 << lvl) - 1) >> lvl;
    endfunction

endpackage

### rtl/core/twcd_queue.sv
// small register queue used between the pipeline parts and at the output
`timescale 1ns / 1ps
`include "tiled_worley_cell_distance_3d_unit_assert.svh"
module twcd_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = twcd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    `TWCD_ASSERT_NOW(a_count_bound, r_count <= CW'(DEPTH), "queue count above depth")
    `TWCD_ASSERT_IMP(a_no_overflow, i_push, !o_full || i_pop, "push into full queue")
    `TWCD_ASSERT_IMP(a_no_underflow, i_pop, !o_empty, "pop from empty queue")
    `TWCD_ASSERT_NXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count did not rise")
endmodule

### rtl/core/twcd_front.sv
// front part: cell floor, wrap modulo period and neighbor cell indexes
`timescale 1ns / 1ps
module twcd_front #(
    parameter int FRAC_BITS = twcd_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [twcd_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [twcd_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [twcd_pkg::COORD_W-1:0]  i_pos_z,
    input  logic [twcd_pkg::PERIOD_W-1:0]        i_tile_period,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [9*twcd_pkg::PERIOD_W+3*FRAC_BITS-1:0] o_data
);
    localparam int IW = twcd_pkg::COORD_W - FRAC_BITS;
    localparam int PWD = twcd_pkg::PERIOD_W;

    logic                 en;
    logic [PWD-1:0]       per;
    logic [twcd_pkg::COORD_W-1:0] pos [0:2];

    logic                 r_v    [0:IW];
    logic [PWD-1:0]       r_rem  [0:IW][0:2];
    logic [IW-1:0]        r_mag  [0:IW][0:2];
    logic                 r_neg  [0:IW][0:2];
    logic [FRAC_BITS-1:0] r_frac [0:IW][0:2];

    logic                 r_vf;
    logic [PWD-1:0]       r_w    [0:2];
    logic [FRAC_BITS-1:0] r_fracf[0:2];
    logic                 r_vn;
    logic [PWD-1:0]       r_wn   [0:2][0:2];
    logic [FRAC_BITS-1:0] r_fracn[0:2];

    assign en     = !i_stall;
    assign per    = (i_tile_period == '0) ? PWD'(1) : i_tile_period;
    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k]  <= '0;
                r_neg[0][k]  <= pos[k][twcd_pkg::COORD_W-1];
                r_mag[0][k]  <= pos[k][twcd_pkg::COORD_W-1]
                              ? IW'(~pos[k][twcd_pkg::COORD_W-1:FRAC_BITS] + 1'b1)
                              : pos[k][twcd_pkg::COORD_W-1:FRAC_BITS];
                r_frac[0][k] <= pos[k][FRAC_BITS-1:0];
            end
        end
    end

    // one remainder bit per stage
    for (genvar s = 0; s < IW; s++) begin : g_div
        logic [PWD:0] trial [0:2];
        always_comb begin
            for (int k = 0; k < 3; k++) begin
                trial[k] = {r_rem[s][k], r_mag[s][k][IW-1-s]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (en) begin
                r_v[s+1] <= r_v[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    r_rem[s+1][k]  <= (trial[k] >= {1'b0, per})
                                    ? PWD'(trial[k] - {1'b0, per}) : PWD'(trial[k]);
                    r_mag[s+1][k]  <= r_mag[s][k];
                    r_neg[s+1][k]  <= r_neg[s][k];
                    r_frac[s+1][k] <= r_frac[s][k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
            r_vn <= 1'b0;
        end else if (en) begin
            r_vf <= r_v[IW];
            r_vn <= r_vf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_w[k]     <= (r_neg[IW][k] && r_rem[IW][k] != '0)
                            ? per - r_rem[IW][k] : r_rem[IW][k];
                r_fracf[k] <= r_frac[IW][k];
                r_wn[k][0] <= (r_w[k] == '0) ? per - 1'b1 : r_w[k] - 1'b1;
                r_wn[k][1] <= r_w[k];
                r_wn[k][2] <= (r_w[k] == per - 1'b1) ? '0 : r_w[k] + 1'b1;
                r_fracn[k] <= r_fracf[k];
            end
        end
    end

    always_comb begin
        o_data = '0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                o_data[(k*3+j)*PWD +: PWD] = r_wn[k][j];
            end
            o_data[9*PWD + k*FRAC_BITS +: FRAC_BITS] = r_fracn[k];
        end
    end

    assign o_valid = r_vn;
endmodule

### rtl/core/twcd_back.sv
// back part: 27 neighbor hashes, squared distances, min tree and square root
`timescale 1ns / 1ps
module twcd_back #(
    parameter int FRAC_BITS = twcd_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [9*twcd_pkg::PERIOD_W+3*FRAC_BITS-1:0] i_data,
    input  logic [twcd_pkg::SEED_W-1:0]          i_hash_seed,
    input  logic                                 i_stall,
    output logic                                 o_pop,
    output logic                                 o_valid,
    output logic [twcd_pkg::DIST_W-1:0]          o_nearest_distance
);
    localparam int PWD = twcd_pkg::PERIOD_W;
    localparam int NB  = twcd_pkg::NUM_NB;
    localparam int EW  = FRAC_BITS + 2;
    localparam int QW  = 2 * FRAC_BITS + 2;
    localparam int SW  = 2 * FRAC_BITS + 4;
    localparam int RT  = FRAC_BITS + 2;
    localparam int RMW = FRAC_BITS + 5;
    localparam int XW  = FRAC_BITS + 18;
    localparam int SH  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 16 - FRAC_BITS;
    localparam int OSH = FRAC_BITS - twcd_pkg::OFFSET_BITS;
    localparam int LV  = twcd_pkg::TREE_LVLS;

    logic                 en;
    logic [PWD-1:0]       wn [0:2][0:2];
    logic [FRAC_BITS-1:0] fr [0:2];
    logic [31:0]          mul_k [0:2];

    logic                 r0_v;
    logic [31:0]          r0_m    [0:2][0:2];
    logic [FRAC_BITS-1:0] r0_frac [0:2];
    logic                 r1_v;
    logic [31:0]          r1_h    [0:NB-1];
    logic [FRAC_BITS-1:0] r1_frac [0:2];
    logic                 r2_v;
    logic [31:0]          r2_h    [0:NB-1];
    logic [FRAC_BITS-1:0] r2_frac [0:2];
    logic                 r3_v;
    logic signed [EW-1:0] r3_e    [0:NB-1][0:2];
    logic                 r4_v;
    logic [QW-1:0]        r4_sq   [0:NB-1][0:2];
    logic                 r_lv_v  [0:LV];
    logic [SW-1:0]        r_lvl   [0:LV][0:NB-1];
    logic                 r_sq_v    [0:RT];
    logic [SW-1:0]        r_sq_val  [0:RT];
    logic [RMW-1:0]       r_sq_rem  [0:RT];
    logic [RT-1:0]        r_sq_root [0:RT];
    logic [XW-1:0]        root_x;
    logic [XW-1:0]        root_s;

    assign en    = !i_stall;
    assign o_pop = en && i_valid;
    assign mul_k[0] = twcd_pkg::HASH_MUL_X;
    assign mul_k[1] = twcd_pkg::HASH_MUL_Y;
    assign mul_k[2] = twcd_pkg::HASH_MUL_Z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                wn[k][j] = i_data[(k*3+j)*PWD +: PWD];
            end
            fr[k] = i_data[9*PWD + k*FRAC_BITS +: FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_lv_v[0] <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_lv_v[0] <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r0_m[k][j] <= {16'b0, wn[k][j]} * mul_k[k];
                end
                r0_frac[k] <= fr[k];
                r1_frac[k] <= r0_frac[k];
                r2_frac[k] <= r1_frac[k];
            end
        end
    end

    for (genvar c = 0; c < NB; c++) begin : g_nb
        localparam int JX = c % 3;
        localparam int JY = (c / 3) % 3;
        localparam int JZ = c / 9;
        localparam logic signed [EW-1:0] BX = EW'((1 - JX) * (1 << FRAC_BITS));
        localparam logic signed [EW-1:0] BY = EW'((1 - JY) * (1 << FRAC_BITS));
        localparam logic signed [EW-1:0] BZ = EW'((1 - JZ) * (1 << FRAC_BITS));
        logic [31:0]          sum;
        logic [31:0]          hf;
        logic [FRAC_BITS-1:0] off [0:2];
        logic signed [2*EW-1:0] prod [0:2];

        always_comb begin
            sum = r0_m[0][JX] + r0_m[1][JY] + r0_m[2][JZ] + i_hash_seed;
            hf  = r2_h[c] ^ (r2_h[c] >> 16);
            off[0] = FRAC_BITS'(hf[9:0]) << OSH;
            off[1] = FRAC_BITS'(hf[19:10]) << OSH;
            off[2] = FRAC_BITS'(hf[29:20]) << OSH;
            for (int k = 0; k < 3; k++) begin
                prod[k] = r3_e[c][k] * r3_e[c][k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r1_h[c] <= sum ^ (sum >> 13);
                r2_h[c] <= r1_h[c] * twcd_pkg::HASH_MIX;
                r3_e[c][0] <= $signed({2'b00, r2_frac[0]}) - $signed({2'b00, off[0]}) + BX;
                r3_e[c][1] <= $signed({2'b00, r2_frac[1]}) - $signed({2'b00, off[1]}) + BY;
                r3_e[c][2] <= $signed({2'b00, r2_frac[2]}) - $signed({2'b00, off[2]}) + BZ;
                for (int k = 0; k < 3; k++) begin
                    r4_sq[c][k] <= prod[k][QW-1:0];
                end
                r_lvl[0][c] <= SW'(r4_sq[c][0]) + SW'(r4_sq[c][1]) + SW'(r4_sq[c][2]);
            end
        end
    end

    // registered min tree over the 27 sums
    for (genvar l = 1; l <= LV; l++) begin : g_lvl
        localparam int NP = twcd_pkg::lvl_size(l - 1);
        localparam int NC = twcd_pkg::lvl_size(l);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lv_v[l] <= 1'b0;
            end else if (en) begin
                r_lv_v[l] <= r_lv_v[l-1];
            end
        end
        for (genvar i = 0; i < NC; i++) begin : g_node
            if (2 * i + 1 < NP) begin : g_min
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_lvl[l][i] <= (r_lvl[l-1][2*i+1] < r_lvl[l-1][2*i])
                                     ? r_lvl[l-1][2*i+1] : r_lvl[l-1][2*i];
                    end
                end
            end else begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_lvl[l][i] <= r_lvl[l-1][2*i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= r_lv_v[LV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_val[0]  <= r_lvl[LV][0];
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    // digit by digit square root, one result bit per stage
    for (genvar t = 0; t < RT; t++) begin : g_sqrt
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        always_comb begin
            rem_sh = {r_sq_rem[t][RMW-3:0], r_sq_val[t][SW-1-2*t -: 2]};
            trial  = RMW'({r_sq_root[t], 2'b01});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[t+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[t+1] <= r_sq_v[t];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_val[t+1] <= r_sq_val[t];
                if (rem_sh >= trial) begin
                    r_sq_rem[t+1]  <= rem_sh - trial;
                    r_sq_root[t+1] <= {r_sq_root[t][RT-2:0], 1'b1};
                end else begin
                    r_sq_rem[t+1]  <= rem_sh;
                    r_sq_root[t+1] <= {r_sq_root[t][RT-2:0], 1'b0};
                end
            end
        end
    end

    assign root_x = XW'(r_sq_root[RT]);

    if (FRAC_BITS >= 16) begin : g_shr
        assign root_s = root_x >> SH;
    end else begin : g_shl
        assign root_s = root_x << SH;
    end

    assign o_nearest_distance = (root_s > XW'(twcd_pkg::OUT_MAX))
                              ? twcd_pkg::OUT_MAX : root_s[twcd_pkg::DIST_W-1:0];
    assign o_valid = en && r_sq_v[RT];
endmodule

### rtl/core/tiled_worley_cell_distance_3d_unit.sv
// top level of the tiled 3d worley distance unit
`timescale 1ns / 1ps
// Takes one sample point per cycle while full is low and returns one distance
// per point, in order. A transaction passes the front part (cell floor and wrap
// of the cell index modulo the period, one remainder bit per stage) into a
// 4-entry queue, then the back part (27 neighbor hashes, squared distances, a
// 5-level min tree and a one-bit-per-stage square root) into a 4-entry output
// queue. Sustained rate is one transaction per cycle while pop keeps up. Both
// parts stall only on their own downstream queue being full.
module tiled_worley_cell_distance_3d_unit #(
    parameter int FRAC_BITS = twcd_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [twcd_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [twcd_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [twcd_pkg::COORD_W-1:0] i_pos_z,
    output logic                                empty,
    input  logic                                pop,
    output logic [twcd_pkg::DIST_W-1:0]         o_nearest_distance,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [twcd_pkg::APB_AW-1:0]         paddr,
    input  logic [twcd_pkg::APB_DW-1:0]         pwdata,
    output logic [twcd_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    localparam int MW = 9 * twcd_pkg::PERIOD_W + 3 * FRAC_BITS;

    logic [twcd_pkg::PERIOD_W-1:0] r_tile_period;
    logic [twcd_pkg::SEED_W-1:0]   r_hash_seed;
    logic                          wr_en;
    logic                          f_valid;
    logic [MW-1:0]                 f_data;
    logic                          mid_full;
    logic                          mid_empty;
    logic [MW-1:0]                 mid_data;
    logic                          b_pop;
    logic                          b_valid;
    logic [twcd_pkg::DIST_W-1:0]   b_dist;
    logic                          out_full;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_period <= twcd_pkg::PERIOD_RESET;
            r_hash_seed   <= twcd_pkg::SEED_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                twcd_pkg::REG_TILE_PERIOD: r_tile_period <= pwdata[twcd_pkg::PERIOD_W-1:0];
                twcd_pkg::REG_HASH_SEED:   r_hash_seed   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            twcd_pkg::REG_TILE_PERIOD: prdata = twcd_pkg::APB_DW'(r_tile_period);
            twcd_pkg::REG_HASH_SEED:   prdata = r_hash_seed;
            default:                   prdata = '0;
        endcase
    end

    assign full = mid_full;

    twcd_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (push && !full),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_tile_period (r_tile_period),
        .i_stall       (mid_full),
        .o_valid       (f_valid),
        .o_data        (f_data)
    );

    twcd_queue #(
        .WIDTH(MW),
        .DEPTH(twcd_pkg::QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !mid_full),
        .i_data  (f_data),
        .i_pop   (b_pop),
        .o_data  (mid_data),
        .o_full  (mid_full),
        .o_empty (mid_empty)
    );

    twcd_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (!mid_empty),
        .i_data             (mid_data),
        .i_hash_seed        (r_hash_seed),
        .i_stall            (out_full),
        .o_pop              (b_pop),
        .o_valid            (b_valid),
        .o_nearest_distance (b_dist)
    );

    twcd_queue #(
        .WIDTH(twcd_pkg::DIST_W),
        .DEPTH(twcd_pkg::QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid),
        .i_data  (b_dist),
        .i_pop   (pop && !empty),
        .o_data  (o_nearest_distance),
        .o_full  (out_full),
        .o_empty (empty)
    );
endmodule

### tb/tiled_worley_cell_distance_3d_unit_tb.sv
// self-checking testbench for the tiled 3d worley distance unit
`timescale 1ns / 1ps
module tiled_worley_cell_distance_3d_unit_tb;
    import twcd_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_sample;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic signed [COORD_W-1:0] i_pos_x;
    logic signed [COORD_W-1:0] i_pos_y;
    logic signed [COORD_W-1:0] i_pos_z;
    logic                      empty;
    logic                      pop;
    logic [DIST_W-1:0]         o_nearest_distance;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    t_sample           sample_q[$];
    logic [DIST_W-1:0] dist_q[$];
    logic [PERIOD_W-1:0] cur_period;
    logic [SEED_W-1:0]   cur_seed;
    int  gap_left;
    int  pop_wait;
    int  err_cnt;
    int  cycle_cnt;
    bit  no_idle;
    bit  hold_rx;

    tiled_worley_cell_distance_3d_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .empty(empty), .pop(pop), .o_nearest_distance(o_nearest_distance),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] cell_hash(input logic [31:0] wx, input logic [31:0] wy,
                                              input logic [31:0] wz, input logic [31:0] seed);
        logic [31:0] h;
        h = wx * HASH_MUL_X;
        h = h + wy * HASH_MUL_Y;
        h = h + wz * HASH_MUL_Z;
        h = h + seed;
        h = (h ^ (h >> 13)) * HASH_MIX;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [DIST_W-1:0] worley_dist(input t_sample s,
                                                      input logic [PERIOD_W-1:0] per,
                                                      input logic [SEED_W-1:0] seed);
        longint pos[3];
        longint base[3];
        longint c[3];
        logic [31:0] w[3];
        logic [31:0] h;
        longint p;
        longint r;
        longint e;
        longint unsigned d;
        longint unsigned best;
        longint unsigned root;
        pos[0] = s.x;
        pos[1] = s.y;
        pos[2] = s.z;
        p = (per == 0) ? 1 : longint'(per);
        best = 64'd999 << 32;
        for (int a = 0; a < 3; a++) base[a] = pos[a] >>> 16;
        for (int dz = -1; dz <= 1; dz++) begin
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    c[0] = base[0] + dx;
                    c[1] = base[1] + dy;
                    c[2] = base[2] + dz;
                    for (int a = 0; a < 3; a++) begin
                        r = c[a] % p;
                        if (r < 0) r = r + p;
                        w[a] = r[31:0];
                    end
                    h = cell_hash(w[0], w[1], w[2], seed);
                    d = 0;
                    for (int a = 0; a < 3; a++) begin
                        e = pos[a] - (c[a] * 65536
                            + (longint'((h >> (10 * a)) & 32'h3FF) << 6));
                        d = d + longint'(e * e);
                    end
                    if (d < best) best = d;
                end
            end
        end
        root = floor_root(best);
        if (root > OUT_MAX) root = OUT_MAX;
        return root[DIST_W-1:0];
    endfunction

    function automatic int draw_wait();
        if (no_idle) return 0;
        return $urandom_range(0, 17);
    endfunction

    // sender
    always @(posedge i_clk) begin
        t_sample s;
        int g;
        if (!i_rst_n) begin
            push <= 1'b0;
            gap_left <= 0;
        end else begin
            if (push && !full) begin
                s.x = i_pos_x;
                s.y = i_pos_y;
                s.z = i_pos_z;
                dist_q.push_back(worley_dist(s, cur_period, cur_seed));
                g = draw_wait();
                if (g == 0 && sample_q.size() > 0) begin
                    s = sample_q.pop_front();
                    i_pos_x <= s.x;
                    i_pos_y <= s.y;
                    i_pos_z <= s.z;
                end else begin
                    push <= 1'b0;
                    gap_left <= g;
                end
            end else if (!push) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (sample_q.size() > 0) begin
                    s = sample_q.pop_front();
                    i_pos_x <= s.x;
                    i_pos_y <= s.y;
                    i_pos_z <= s.z;
                    push <= 1'b1;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        logic [DIST_W-1:0] want;
        int g;
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_wait <= 0;
        end else begin
            if (pop && !empty) begin
                if (dist_q.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10)
                        $display("unexpected transaction: distance %0d", o_nearest_distance);
                end else begin
                    want = dist_q.pop_front();
                    if (o_nearest_distance !== want) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= 10)
                            $display("nearest_distance: expected %0d, got %0d",
                                     want, o_nearest_distance);
                    end
                end
                g = draw_wait();
                if (g != 0 || hold_rx) begin
                    pop <= 1'b0;
                    pop_wait <= g;
                end
            end else if (!pop) begin
                if (pop_wait > 0) pop_wait <= pop_wait - 1;
                else if (!hold_rx) pop <= 1'b1;
            end
        end
    end

    // long receiver hold-off during the gapless phase so the unit fills up
    initial begin
        hold_rx = 1'b0;
        wait (no_idle);
        repeat (20) @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 2000000) begin
            $display("tiled_worley_cell_distance_3d_unit: mismatch");
            $finish;
        end
    end

    task automatic reg_write(input logic reg_idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_TILE_PERIOD) cur_period = val[PERIOD_W-1:0];
        else cur_seed = val;
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || push || dist_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic add_sample(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        t_sample s;
        s.x = x;
        s.y = y;
        s.z = z;
        sample_q.push_back(s);
    endtask

    function automatic logic [31:0] near_coord(input int span);
        int c;
        c = int'($urandom_range(0, 2 * span)) - span;
        return {c[15:0], 16'($urandom)};
    endfunction

    task automatic random_samples(input int n);
        int span;
        span = (cur_period == 0) ? 4 : ((cur_period > 15000) ? 30000 : 2 * cur_period + 2);
        repeat (n) begin
            if ($urandom_range(0, 9) < 3)
                add_sample($urandom, $urandom, $urandom);
            else
                add_sample(near_coord(span), near_coord(span), near_coord(span));
        end
    endtask

    initial begin
        logic [15:0] periods[6];
        err_cnt = 0;
        cycle_cnt = 0;
        no_idle = 1'b0;
        cur_period = PERIOD_RESET;
        cur_seed = SEED_RESET;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed points at reset settings
        add_sample(32'h0, 32'h0, 32'h0);
        add_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        add_sample(32'h80000000, 32'h80000000, 32'h80000000);
        add_sample(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_sample(32'h00010000, 32'hFFFF0000, 32'h000F0000);
        add_sample(32'h00100000, 32'hFFF00000, 32'h0000FFFF);
        add_sample(32'h0000FFFF, 32'h00008000, 32'hFFFF8000);
        add_sample(32'h7FFF0000, 32'h80000001, 32'h00000001);
        add_sample(32'h55555555, 32'hAAAAAAAA, 32'h5A5A5A5A);
        add_sample(32'hAAAAAAAA, 32'h55555555, 32'hA5A5A5A5);
        add_sample(32'hFFEFFFFF, 32'h0010FFFF, 32'hFFF0FFFF);
        drain();

        periods[0] = 16'd16;
        periods[1] = 16'd1;
        periods[2] = 16'd0;
        periods[3] = 16'd65535;
        periods[4] = 16'd3;
        periods[5] = 16'd7;
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(REG_TILE_PERIOD, {16'($urandom), periods[ph]});
            case (ph)
                2: reg_write(REG_HASH_SEED, 32'hFFFFFFFF);
                5: reg_write(REG_HASH_SEED, 32'h0);
                default: reg_write(REG_HASH_SEED, $urandom);
            endcase
            no_idle = (ph == 3);
            if (ph == 2) begin
                add_sample(32'hFFFF0000, 32'h00000000, 32'h7FFFFFFF);
                add_sample(32'h80000000, 32'hFFFFFFFF, 32'h00010000);
            end
            random_samples(122);
            drain();
        end

        if (err_cnt == 0 && dist_q.size() == 0) begin
            $display("tiled_worley_cell_distance_3d_unit: match");
        end else begin
            $display("tiled_worley_cell_distance_3d_unit: mismatch");
        end
        $finish;
    end

endmodule
